FILE: hw/rtl/amagc_pkg.sv
// Package for the AM envelope detector with AGC.
// Holds register indexes, reset values, op codes, the op program and the
// command and status structs shared by the controller and the datapath.
`default_nettype none
package amagc_pkg;

  localparam int W_BITS    = 17;
  localparam int LVL_BITS  = 16;
  localparam int IDX_BITS  = 3;
  localparam int PC_BITS   = 5;
  localparam int PWR_BITS  = 32;
  localparam int NUM_BITS  = 32;
  localparam int DEN_BITS  = 33;

  localparam logic [W_BITS-1:0] FULL_WEIGHT = 17'd65536;

  localparam logic [IDX_BITS-1:0] REG_AGC_WEIGHT     = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_DC_WEIGHT      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_POWER_WEIGHT   = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_CARRIER_LEVEL  = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_SIDEBAND_LEVEL = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_KNEE           = 3'd5;

  localparam logic [W_BITS-1:0]   RST_AGC_WEIGHT     = 17'd13;
  localparam logic [W_BITS-1:0]   RST_DC_WEIGHT      = 17'd655;
  localparam logic [W_BITS-1:0]   RST_POWER_WEIGHT   = 17'd13;
  localparam logic [LVL_BITS-1:0] RST_CARRIER_LEVEL  = 16'd8000;
  localparam logic [LVL_BITS-1:0] RST_SIDEBAND_LEVEL = 16'd6553;
  localparam logic [LVL_BITS-1:0] RST_KNEE           = 16'd50;
  localparam logic [PWR_BITS-1:0] RST_POWER          = 32'd65536;

  typedef enum logic [4:0] {
    OP_CA_MUL, OP_CA_MAC, OP_CA_WR,
    OP_DC_MUL, OP_DC_MAC, OP_DC_WR,
    OP_DIFF, OP_ABS, OP_SQ, OP_SQ_SAT,
    OP_PW_MUL, OP_PW_MAC, OP_PW_WR,
    OP_DIV_N, OP_NEWT,
    OP_DIV_DC, OP_GDC, OP_DIV_AC, OP_GAC,
    OP_SCALE, OP_MUL, OP_SAT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic exec;
    logic load;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

  function automatic logic is_div(input op_t op);
    return (op == OP_DIV_N) || (op == OP_DIV_DC) || (op == OP_DIV_AC);
  endfunction

  function automatic op_t op_at(input logic [PC_BITS-1:0] pc);
    op_t op;
    unique case (pc)
      5'd0:  op = OP_CA_MUL;
      5'd1:  op = OP_CA_MAC;
      5'd2:  op = OP_CA_WR;
      5'd3:  op = OP_DC_MUL;
      5'd4:  op = OP_DC_MAC;
      5'd5:  op = OP_DC_WR;
      5'd6:  op = OP_DIFF;
      5'd7:  op = OP_ABS;
      5'd8:  op = OP_SQ;
      5'd9:  op = OP_SQ_SAT;
      5'd10: op = OP_PW_MUL;
      5'd11: op = OP_PW_MAC;
      5'd12: op = OP_PW_WR;
      5'd13: op = OP_DIV_N;
      5'd14: op = OP_NEWT;
      5'd15: op = OP_DIV_N;
      5'd16: op = OP_NEWT;
      5'd17: op = OP_DIV_N;
      5'd18: op = OP_NEWT;
      5'd19: op = OP_DIV_N;
      5'd20: op = OP_NEWT;
      5'd21: op = OP_DIV_DC;
      5'd22: op = OP_GDC;
      5'd23: op = OP_DIV_AC;
      5'd24: op = OP_GAC;
      5'd25: op = OP_SCALE;
      5'd26: op = OP_MUL;
      default: op = OP_SAT;
    endcase
    return op;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/amagc_in_if.sv
// Input channel: one complex baseband item (I and Q).
// Depends on nothing.
`default_nettype none
interface amagc_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] i_sample;
  logic signed [SAMPLE_BITS-1:0] q_sample;
  modport source (output valid, output i_sample, output q_sample, input ready);
  modport sink   (input valid, input i_sample, input q_sample, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/amagc_out_if.sv
// Output channel: one audio item and its clip flag.
// Depends on nothing.
`default_nettype none
interface amagc_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] audio_sample;
  logic                          clipped;
  modport source (output valid, output audio_sample, output clipped, input ready);
  modport sink   (input valid, input audio_sample, input clipped, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/amagc_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on amagc_pkg.
`default_nettype none
module amagc_div
  import amagc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [NUM_BITS-1:0] num,
  input  wire logic [DEN_BITS-1:0] den,
  output logic      [NUM_BITS-1:0] quo,
  output logic                     done
);
  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DEN_BITS-1:0] rem;
  logic [DEN_BITS-1:0] dreg;
  logic [DEN_BITS:0]   trial;
  logic                fits;

  assign trial = {rem, quo[NUM_BITS-1]};
  assign fits  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      rem <= fits ? DEN_BITS'(trial - {1'b0, dreg}) : trial[DEN_BITS-1:0];
      quo <= {quo[NUM_BITS-2:0], fits};
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/amagc_ctrl.sv
// Controller: steps through the op program, waits on the divider and
// hands finished items to the output register. Depends on amagc_pkg.
`default_nettype none
module amagc_ctrl
  import amagc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cmd_t         cmd,
  input  wire status_t status
);
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [PC_BITS-1:0]   pc, pc_next;
  logic                 out_valid_next;
  op_t                  op;

  assign op       = op_at(pc);
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next     = state;
    pc_next        = pc;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = op;
    cmd.exec       = 1'b0;
    cmd.load       = 1'b0;
    cmd.load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          pc_next    = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (op == OP_SAT) begin
          if (!out_valid || out_ready) begin
            cmd.load_out   = 1'b1;
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd.exec = 1'b1;
          if (is_div(op)) begin
            state_next = ST_WAIT;
          end else begin
            pc_next = pc + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (status.div_done) begin
          pc_next    = pc + 1'b1;
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pc        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/amagc_dp.sv
// Datapath: config registers, filter state, shared multiplier, divider,
// and the output register. Depends on amagc_pkg and amagc_div.
`default_nettype none
module amagc_dp
  import amagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [IDX_BITS-1:0]           cfg_index,
  input  wire logic [W_BITS-1:0]             cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
  input  wire logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic signed [SAMPLE_BITS-1:0]      audio_sample,
  output logic                               clipped,
  input  wire cmd_t                          cmd,
  output status_t                            status
);
  localparam int CW = (SAMPLE_BITS + 1 > W_BITS) ? SAMPLE_BITS + 1 : W_BITS;
  localparam int MA = 34;
  localparam int MB = CW + 2;
  localparam int AW = MA + MB;
  localparam logic signed [AW-1:0] OUT_HI = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [AW-1:0] OUT_LO = -OUT_HI - AW'(1);

  logic [W_BITS-1:0]   agc_w, dc_w, pw_w;
  logic [LVL_BITS-1:0] clev, slev, knee;

  logic [CW-1:0]          mag, carrier, dcav, vabs;
  logic signed [CW:0]     v, vs;
  logic [PWR_BITS-1:0]    power, sq, g;
  logic [LVL_BITS-1:0]    gdc, gac, gain;
  logic signed [AW-1:0]   acc;

  logic [SAMPLE_BITS-1:0] ai, aq;
  logic [SAMPLE_BITS:0]   mag_in;
  logic [W_BITS-1:0]      ka, kd, kp;
  logic signed [MA-1:0]   ma;
  logic signed [MB-1:0]   mb;
  logic signed [AW-1:0]   prod;
  logic [AW-1:0]          shifted;
  logic [PWR_BITS-1:0]    pw_sat;
  logic [LVL_BITS-1:0]    gmin;
  logic                   div_start;
  logic [NUM_BITS-1:0]    div_num, quo;
  logic [DEN_BITS-1:0]    div_den, den_raw;
  logic [PWR_BITS:0]      newt_sum;

  always_comb begin
    ai = i_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-i_sample) : i_sample;
    aq = q_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-q_sample) : q_sample;
    mag_in = (ai > aq) ? ({1'b0, ai} + {3'b0, aq[SAMPLE_BITS-1:2]})
                       : ({1'b0, aq} + {3'b0, ai[SAMPLE_BITS-1:2]});
  end

  assign ka = (agc_w > FULL_WEIGHT) ? FULL_WEIGHT : agc_w;
  assign kd = (dc_w > FULL_WEIGHT) ? FULL_WEIGHT : dc_w;
  assign kp = (pw_w > FULL_WEIGHT) ? FULL_WEIGHT : pw_w;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_CA_MUL: begin ma = MA'(ka); mb = MB'(mag); end
      OP_CA_MAC: begin ma = MA'(FULL_WEIGHT - ka); mb = MB'(carrier); end
      OP_DC_MUL: begin ma = MA'(kd); mb = MB'(mag); end
      OP_DC_MAC: begin ma = MA'(FULL_WEIGHT - kd); mb = MB'(dcav); end
      OP_SQ:     begin ma = MA'(vabs); mb = MB'(vabs); end
      OP_PW_MUL: begin ma = MA'(sq); mb = MB'(kp); end
      OP_PW_MAC: begin ma = MA'(power); mb = MB'(FULL_WEIGHT - kp); end
      OP_MUL:    begin ma = MA'(gain); mb = MB'(vs); end
      default: ;
    endcase
  end

  assign prod     = AW'(ma) * AW'(mb);
  assign shifted  = acc >>> 16;
  assign pw_sat   = (shifted > AW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : shifted[PWR_BITS-1:0];
  assign gmin     = (gac < gdc) ? gac : gdc;
  assign newt_sum = {1'b0, g} + {1'b0, quo};

  always_comb begin
    div_num = '0;
    den_raw = '0;
    unique case (cmd.op)
      OP_DIV_N:  begin div_num = power; den_raw = DEN_BITS'(g); end
      OP_DIV_DC: begin
        div_num = NUM_BITS'(clev);
        den_raw = DEN_BITS'(carrier) + DEN_BITS'(knee);
      end
      OP_DIV_AC: begin
        div_num = NUM_BITS'(slev);
        den_raw = DEN_BITS'(g) + DEN_BITS'(knee);
      end
      default: ;
    endcase
    div_den   = (den_raw == '0) ? DEN_BITS'(1) : den_raw;
    div_start = cmd.exec && is_div(cmd.op);
  end

  amagc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (status.div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      agc_w <= RST_AGC_WEIGHT;
      dc_w  <= RST_DC_WEIGHT;
      pw_w  <= RST_POWER_WEIGHT;
      clev  <= RST_CARRIER_LEVEL;
      slev  <= RST_SIDEBAND_LEVEL;
      knee  <= RST_KNEE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AGC_WEIGHT:     agc_w <= cfg_data;
        REG_DC_WEIGHT:      dc_w  <= cfg_data;
        REG_POWER_WEIGHT:   pw_w  <= cfg_data;
        REG_CARRIER_LEVEL:  clev  <= cfg_data[LVL_BITS-1:0];
        REG_SIDEBAND_LEVEL: slev  <= cfg_data[LVL_BITS-1:0];
        REG_KNEE:           knee  <= cfg_data[LVL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier <= CW'(FULL_WEIGHT);
      dcav    <= CW'(FULL_WEIGHT);
      power   <= RST_POWER;
    end else if (cmd.exec) begin
      unique case (cmd.op)
        OP_CA_WR: carrier <= shifted[CW-1:0];
        OP_DC_WR: dcav    <= shifted[CW-1:0];
        OP_PW_WR: power   <= pw_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) mag <= CW'(mag_in);
    if (cmd.exec) begin
      unique case (cmd.op)
        OP_CA_MUL, OP_DC_MUL, OP_SQ, OP_PW_MUL, OP_MUL: acc <= prod;
        OP_CA_MAC, OP_DC_MAC, OP_PW_MAC:                acc <= acc + prod;
        OP_DIFF:   v    <= $signed({1'b0, mag}) - $signed({1'b0, dcav});
        OP_ABS:    vabs <= v[CW] ? CW'(-v) : v[CW-1:0];
        OP_SQ_SAT: sq   <= (acc > AW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : acc[PWR_BITS-1:0];
        OP_PW_WR:  g    <= pw_sat >> 3;
        OP_NEWT:   g    <= (g == '0) ? '0 : newt_sum[PWR_BITS:1];
        OP_GDC:    gdc  <= quo[LVL_BITS-1:0];
        OP_GAC:    gac  <= quo[LVL_BITS-1:0];
        OP_SCALE: begin
          if (gmin == '0) begin
            gain <= LVL_BITS'(1);
            vs   <= v >>> 1;
          end else begin
            gain <= gmin;
            vs   <= v;
          end
        end
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      if (acc > OUT_HI) begin
        audio_sample <= OUT_HI[SAMPLE_BITS-1:0];
        clipped      <= 1'b1;
      end else if (acc < OUT_LO) begin
        audio_sample <= OUT_LO[SAMPLE_BITS-1:0];
        clipped      <= 1'b1;
      end else begin
        audio_sample <= acc[SAMPLE_BITS-1:0];
        clipped      <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/am_envelope_agc_demodulator_core.sv
// AM envelope detector with AGC, one item in flight at a time.
// Each item runs the op program: 21 ops around one shared multiplier, six
// divisions on one serial divider (four Newton steps, two gains) and one
// saturation step. A new item is accepted only in idle, once the last one has
// gone to the output register; a waiting result stalls the saturation step.
// The output register lets the next item start while a result waits.
// Synchronous active-high reset restores config registers and filter state.
`default_nettype none
module am_envelope_agc_demodulator_core
  import amagc_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  amagc_in_if.sink                 in_ch,
  amagc_out_if.source              out_ch,
  input  wire logic                cfg_we,
  input  wire logic [IDX_BITS-1:0] cfg_index,
  input  wire logic [W_BITS-1:0]   cfg_data
);
  cmd_t    cmd;
  status_t status;

  amagc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  amagc_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .i_sample     (in_ch.i_sample),
    .q_sample     (in_ch.q_sample),
    .audio_sample (out_ch.audio_sample),
    .clipped      (out_ch.clipped),
    .cmd          (cmd),
    .status       (status)
  );
endmodule
`default_nettype wire
